FILE: hdl/tile_pixel_fetcher_assert.svh
// assertion helpers shared by the fetcher modules
`ifndef TILE_PIXEL_FETCHER_ASSERT_SVH
`define TILE_PIXEL_FETCHER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tile fetcher check failed");

// next-cycle implication, checked out of reset
`define TPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tile fetcher check failed");

`endif

FILE: hdl/tpf_pkg.sv
package tpf_pkg;

	localparam int VRAM_DEPTH  = 8192;
	localparam int VRAM_AW     = $clog2(VRAM_DEPTH);
	localparam int FIFO_DEPTH  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [4:0] PUSH_LEVEL = 5'(FIFO_DEPTH / 2);
	localparam logic [3:0] PIX_COUNT  = 4'd8;

	// register indexes of the configuration port
	localparam logic [2:0] CFG_BG_MAP      = 3'd0;
	localparam logic [2:0] CFG_WIN_MAP     = 3'd1;
	localparam logic [2:0] CFG_DATA_UNSIGN = 3'd2;
	localparam logic [2:0] CFG_SCROLL_X    = 3'd3;
	localparam logic [2:0] CFG_SCROLL_Y    = 3'd4;
	localparam logic [2:0] CFG_WINDOW_Y    = 3'd5;
	localparam logic [2:0] CFG_SPRITE_MODE = 3'd6;

	typedef enum logic [1:0] {
		OP_FETCH,
		OP_WRITE,
		OP_RESTART,
		OP_WINDOW
	} op_t;

	typedef enum logic [1:0] {
		PH_GET,
		PH_LOW,
		PH_HIGH,
		PH_SLEEP
	} phase_t;

	typedef struct packed {
		logic       bg_map_select;
		logic       window_map_select;
		logic       tile_data_unsigned;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] window_y;
		logic       sprite_mode;
	} cfg_t;

	// one tile row handed from front to back
	typedef struct packed {
		logic [7:0] plane_low;
		logic [7:0] plane_high;
		logic [3:0] start;
		logic       xflip;
		logic       palette;
		logic       behind;
	} push_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       line_y;
		logic [4:0]       fifo_count;
		logic [7:0]       sprite_y;
		logic [7:0]       sprite_x;
		logic [7:0]       sprite_tile;
		logic [7:0]       sprite_flags;
		logic [VRAM_AW-1:0] write_addr;
		logic [7:0]       write_data;
	} in_item_t;

	// decisions made in stage 1, applied in stage 2
	typedef struct packed {
		op_t              op;
		phase_t           phase;
		phase_t           next_phase;
		logic             push;
		logic             emit;
		logic [2:0]       fine;
		logic [VRAM_AW-1:0] sprite_addr;
		logic [3:0]       start;
		logic             xflip;
		logic             palette;
		logic             behind;
	} ctl_t;

endpackage

FILE: hdl/tpf_if.sv
interface tpf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0]  op;
	logic [7:0]  line_y;
	logic [4:0]  fifo_count;
	logic [7:0]  sprite_y;
	logic [7:0]  sprite_x;
	logic [7:0]  sprite_tile;
	logic [7:0]  sprite_flags;
	logic [12:0] write_addr;
	logic [7:0]  write_data;

	modport source (
		output valid, op, line_y, fifo_count, sprite_y, sprite_x, sprite_tile,
		output sprite_flags, write_addr, write_data,
		input  ready
	);
	modport sink (
		input  valid, op, line_y, fifo_count, sprite_y, sprite_x, sprite_tile,
		input  sprite_flags, write_addr, write_data,
		output ready
	);
endinterface

interface tpf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] pixel_color;
	logic       palette_select;
	logic       behind_background;
	logic       last_pixel;

	modport source (
		output valid, pixel_color, palette_select, behind_background, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_color, palette_select, behind_background, last_pixel,
		output ready
	);
endinterface

FILE: hdl/tpf_front.sv
`include "tile_pixel_fetcher_assert.svh"

module tpf_front import tpf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	tpf_in_if.sink fetch_in,
	output logic   q_wr_valid,
	input  logic   q_wr_ready,
	output push_t  q_wr_data
);

	logic [7:0] vram [VRAM_DEPTH];
	logic [7:0] rdata_q;

	phase_t             phase_q;
	logic [4:0]         tile_col_q;
	logic               win_q;
	logic [VRAM_AW-1:0] row_addr_q;
	logic [7:0]         plane_low_q;
	logic [7:0]         plane_high_q;

	logic     s1_valid_q;
	in_item_t item_s1;
	logic     s2_valid_q;
	ctl_t     ctl_s2;

	logic s1_adv;
	logic s2_fire;

	phase_t             nxt_phase;
	logic               push;
	logic               rd_en;
	logic [VRAM_AW-1:0] rd_addr;
	logic [VRAM_AW-1:0] map_addr;
	logic [7:0]         yy_bg;
	logic [7:0]         yy_win;
	logic [4:0]         cx_bg;
	logic [2:0]         spr_row;
	logic [VRAM_AW-1:0] spr_addr;
	logic [3:0]         off;
	logic [3:0]         fifo_sat;
	logic [3:0]         start;
	logic               emit;
	ctl_t               ctl_d;
	logic [8:0]         base_hi;
	logic [7:0]         plane_high_now;

	// input register; stage 1 waits until stage 2 has settled the state
	assign s1_adv         = s1_valid_q && !s2_valid_q;
	assign fetch_in.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (fetch_in.ready) begin
			s1_valid_q <= fetch_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_in.ready && fetch_in.valid) begin
			item_s1.op           <= op_t'(fetch_in.op);
			item_s1.line_y       <= fetch_in.line_y;
			item_s1.fifo_count   <= fetch_in.fifo_count;
			item_s1.sprite_y     <= fetch_in.sprite_y;
			item_s1.sprite_x     <= fetch_in.sprite_x;
			item_s1.sprite_tile  <= fetch_in.sprite_tile;
			item_s1.sprite_flags <= fetch_in.sprite_flags;
			item_s1.write_addr   <= fetch_in.write_addr;
			item_s1.write_data   <= fetch_in.write_data;
		end
	end

	// stage 1 address and decision logic
	assign yy_bg  = cfg.scroll_y + item_s1.line_y;
	assign yy_win = item_s1.line_y - cfg.window_y;
	assign cx_bg  = cfg.scroll_x[7:3] + tile_col_q;

	always_comb begin
		if (win_q) begin
			map_addr = {2'b11, cfg.window_map_select, yy_win[7:3], tile_col_q};
		end else begin
			map_addr = {2'b11, cfg.bg_map_select, yy_bg[7:3], cx_bg};
		end
	end

	// sprite line minus sprite_y plus 16 keeps the same low three bits
	assign spr_row  = (item_s1.line_y[2:0] - item_s1.sprite_y[2:0])
		^ {3{item_s1.sprite_flags[6]}};
	assign spr_addr = {1'b0, item_s1.sprite_tile, spr_row, 1'b0};

	assign off      = (item_s1.sprite_x < 8'd8) ? (PIX_COUNT - {1'b0, item_s1.sprite_x[2:0]})
		: 4'd0;
	assign fifo_sat = (item_s1.fifo_count >= 5'd8) ? PIX_COUNT : item_s1.fifo_count[3:0];
	assign start    = (off > fifo_sat) ? off : fifo_sat;

	always_comb begin
		push = ((phase_q == PH_HIGH) && (item_s1.fifo_count < PUSH_LEVEL) && !cfg.sprite_mode)
			|| ((phase_q == PH_SLEEP) && (item_s1.fifo_count <= PUSH_LEVEL));
	end

	// a sprite row that starts past the last column still ends the fetch
	assign emit = push && (!cfg.sprite_mode || !start[3]);

	always_comb begin
		unique case (phase_q)
			PH_GET:   nxt_phase = PH_LOW;
			PH_LOW:   nxt_phase = PH_HIGH;
			PH_HIGH:  nxt_phase = push ? PH_GET : PH_SLEEP;
			PH_SLEEP: nxt_phase = push ? PH_GET : PH_SLEEP;
			default:  nxt_phase = PH_GET;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = map_addr;
		unique case (phase_q)
			PH_GET: begin
				rd_en   = !cfg.sprite_mode;
				rd_addr = map_addr;
			end
			PH_LOW: begin
				rd_en   = 1'b1;
				rd_addr = row_addr_q;
			end
			PH_HIGH: begin
				rd_en   = 1'b1;
				rd_addr = row_addr_q + 1'b1;
			end
			PH_SLEEP: begin
				rd_en   = 1'b0;
				rd_addr = row_addr_q;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = row_addr_q;
			end
		endcase
	end

	always_comb begin
		ctl_d.op          = item_s1.op;
		ctl_d.phase       = phase_q;
		ctl_d.next_phase  = nxt_phase;
		ctl_d.push        = push;
		ctl_d.emit        = emit;
		ctl_d.fine        = win_q ? yy_win[2:0] : yy_bg[2:0];
		ctl_d.sprite_addr = spr_addr;
		ctl_d.start       = cfg.sprite_mode ? start : 4'd0;
		ctl_d.xflip       = cfg.sprite_mode & item_s1.sprite_flags[5];
		ctl_d.palette     = cfg.sprite_mode & item_s1.sprite_flags[4];
		ctl_d.behind      = cfg.sprite_mode & item_s1.sprite_flags[7];
	end

	// video memory: at most one write or one read per item
	always_ff @(posedge clk) begin
		if (s1_adv && (item_s1.op == OP_WRITE)) begin
			vram[item_s1.write_addr] <= item_s1.write_data;
		end
		if (s1_adv && (item_s1.op == OP_FETCH) && rd_en) begin
			rdata_q <= vram[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ctl_s2 <= ctl_d;
		end
	end

	// stage 2: read data back, state update, row request to the queue
	assign q_wr_valid = s2_valid_q && (ctl_s2.op == OP_FETCH) && ctl_s2.emit;
	assign s2_fire    = s2_valid_q && (!q_wr_valid || q_wr_ready);

	assign base_hi        = cfg.tile_data_unsigned ? {1'b0, rdata_q}
		: {~rdata_q[7], rdata_q[7], rdata_q[6:0]};
	assign plane_high_now = (ctl_s2.phase == PH_HIGH) ? rdata_q : plane_high_q;

	always_comb begin
		q_wr_data.plane_low  = plane_low_q;
		q_wr_data.plane_high = plane_high_now;
		q_wr_data.start      = ctl_s2.start;
		q_wr_data.xflip      = ctl_s2.xflip;
		q_wr_data.palette    = ctl_s2.palette;
		q_wr_data.behind     = ctl_s2.behind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
		end else if (s2_fire) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_GET;
			tile_col_q   <= 5'd0;
			win_q        <= 1'b0;
			row_addr_q   <= '0;
			plane_low_q  <= 8'd0;
			plane_high_q <= 8'd0;
		end else if (s2_fire) begin
			unique case (ctl_s2.op)
				OP_RESTART: begin
					phase_q    <= PH_GET;
					tile_col_q <= 5'd0;
					win_q      <= 1'b0;
				end
				OP_WINDOW: begin
					win_q <= 1'b1;
				end
				OP_FETCH: begin
					phase_q <= ctl_s2.next_phase;
					if (ctl_s2.phase == PH_GET) begin
						row_addr_q <= cfg.sprite_mode ? ctl_s2.sprite_addr
							: {base_hi, ctl_s2.fine, 1'b0};
					end
					if (ctl_s2.phase == PH_LOW) begin
						plane_low_q <= rdata_q;
					end
					if (ctl_s2.phase == PH_HIGH) begin
						plane_high_q <= rdata_q;
					end
					if (ctl_s2.push && !cfg.sprite_mode) begin
						tile_col_q <= tile_col_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`TPF_ASSERT_IMP(a_no_sprite_early_push,
		q_wr_valid && (ctl_s2.phase == PH_HIGH), !cfg.sprite_mode)
	`TPF_ASSERT_IMP(a_row_start_in_range, q_wr_valid, !q_wr_data.start[3])
	`TPF_ASSERT_NXT(a_push_returns_to_get,
		s2_fire && (ctl_s2.op == OP_FETCH) && ctl_s2.push, phase_q == PH_GET)

endmodule

FILE: hdl/tpf_queue.sv
module tpf_queue import tpf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  push_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output push_t rd_data
);

	push_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/tpf_back.sv
`include "tile_pixel_fetcher_assert.svh"

module tpf_back import tpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_rd_valid,
	output logic      q_rd_ready,
	input  push_t     q_rd_data,
	tpf_out_if.source pixel_out
);

	push_t      cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;

	logic       out_valid_q;
	logic [1:0] out_color_q;
	logic       out_pal_q;
	logic       out_behind_q;
	logic       out_last_q;

	logic       load_out;
	logic       emit;
	logic       cur_done;
	logic       take;
	logic [2:0] bit_sel;

	assign load_out   = !out_valid_q || pixel_out.ready;
	assign emit       = cur_valid_q && load_out;
	assign cur_done   = emit && (idx_q == 3'd7);
	assign q_rd_ready = !cur_valid_q || cur_done;
	assign take       = q_rd_valid && q_rd_ready;

	// pixel i sits at plane bit 7-i, x flip mirrors it to bit i
	assign bit_sel = cur_q.xflip ? idx_q : ~idx_q;

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (take) begin
			cur_valid_q <= 1'b1;
			idx_q       <= q_rd_data.start[2:0];
		end else if (cur_done) begin
			cur_valid_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_color_q  <= {cur_q.plane_high[bit_sel], cur_q.plane_low[bit_sel]};
			out_pal_q    <= cur_q.palette;
			out_behind_q <= cur_q.behind;
			out_last_q   <= (idx_q == 3'd7);
		end
	end

	assign pixel_out.valid             = out_valid_q;
	assign pixel_out.pixel_color       = out_color_q;
	assign pixel_out.palette_select    = out_pal_q;
	assign pixel_out.behind_background = out_behind_q;
	assign pixel_out.last_pixel        = out_last_q;

	`TPF_ASSERT_IMP(a_idx_not_before_start, cur_valid_q, ({1'b0, idx_q} >= cur_q.start))
	`TPF_ASSERT_IMP(a_taken_row_has_pixels, take, !q_rd_data.start[3])
	`TPF_ASSERT_NXT(a_last_on_row_end, cur_done, out_valid_q && out_last_q)

endmodule

FILE: hdl/tile_pixel_fetcher.sv
// a request passes the input register, stage 1 (at most one video memory access)
// and stage 2 (applies the read data), and waits in stage 1 while stage 2 is busy;
// a pushing fetch step's row goes via the queue to the back end, which shows one
// pixel per cycle from the output register while pixel_out is ready, up to eight
// per push; reset clears the fetch state, the queue and the outputs and loads the
// register defaults; video memory is not cleared and holds garbage until written
module tile_pixel_fetcher import tpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tpf_in_if.sink     fetch_in,
	tpf_out_if.source  pixel_out,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_wr_valid;
	logic  q_wr_ready;
	push_t q_wr_data;
	logic  q_rd_valid;
	logic  q_rd_ready;
	push_t q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bg_map_select      <= 1'b0;
			cfg_q.window_map_select  <= 1'b0;
			cfg_q.tile_data_unsigned <= 1'b1;
			cfg_q.scroll_x           <= 8'd0;
			cfg_q.scroll_y           <= 8'd0;
			cfg_q.window_y           <= 8'd0;
			cfg_q.sprite_mode        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BG_MAP:      cfg_q.bg_map_select      <= cfg_wdata[0];
				CFG_WIN_MAP:     cfg_q.window_map_select  <= cfg_wdata[0];
				CFG_DATA_UNSIGN: cfg_q.tile_data_unsigned <= cfg_wdata[0];
				CFG_SCROLL_X:    cfg_q.scroll_x           <= cfg_wdata;
				CFG_SCROLL_Y:    cfg_q.scroll_y           <= cfg_wdata;
				CFG_WINDOW_Y:    cfg_q.window_y           <= cfg_wdata;
				CFG_SPRITE_MODE: cfg_q.sprite_mode        <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	tpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fetch_in   (fetch_in),
		.q_wr_valid (q_wr_valid),
		.q_wr_ready (q_wr_ready),
		.q_wr_data  (q_wr_data)
	);

	tpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	tpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rd_valid (q_rd_valid),
		.q_rd_ready (q_rd_ready),
		.q_rd_data  (q_rd_data),
		.pixel_out  (pixel_out)
	);

endmodule
